// ===== hw/rtl/stq_pkg.sv =====
package stq_pkg;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_SETUP  = 2'd1,
      MODE_DELETE = 2'd2,
      MODE_QUERY  = 2'd3
   } mode_type;

   typedef enum logic {
      KIND_EXPIRY = 1'b0,
      KIND_QUERY  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      MEM_NONE = 2'd0,
      MEM_MAIN = 2'd1,
      MEM_ROLL = 2'd2
   } mem_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REM_START,
      ST_REM_SCAN,
      ST_WRITE,
      ST_ENQ_START,
      ST_ENQ_SCAN,
      ST_HEAD_SCAN,
      ST_FIRE,
      ST_FLUSH,
      ST_QUERY
   } state_type;

   typedef struct packed {
      mode_type    mode;
      logic [3:0]  slot;
      logic [31:0] now_ticks;
      logic [31:0] delay;
      logic [31:0] reload;
      logic        notify;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  fired_slot;
      logic [31:0] fire_time;
      logic [15:0] count;
      logic        queued;
      logic        last;
   } rsp_type;

endpackage

// ===== hw/rtl/stq_alu.sv =====
module stq_alu #(
   parameter int TW = 32
) (
   input  logic [TW-1:0] op_a,
   input  logic [TW-1:0] op_b,
   output logic [TW-1:0] sum,
   output logic          lt
);

   assign sum = TW'(op_a + op_b);
   assign lt  = op_a < op_b;

endmodule

// ===== hw/rtl/sorted_timer_queue.sv =====
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_stall  stq_pkg::req_type (one command)
// rsp       out        rsp_valid / rsp_stall  stq_pkg::rsp_type (event or answer)
//
// Commands are taken one at a time; the block stalls req until the current one is done.
// Each pass over the slots visits them in turn through one shared adder and comparator.
// A delete unlinks a queued slot in a scan that closes its rank gap; a setup then writes and relinks it.
// A tick rescans each queue after its last move or fire; each timer moved or fired is unlinked,
// then linked again if moved or reloaded, and a final flush step sends any held event.
// Reset empties both queues at once; rsp_stall holds the sequencer only when a result waits and another must go out.
module sorted_timer_queue #(
   parameter int SLOTS     = 16,
   parameter int TICK_BITS = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stq_pkg::rsp_type rsp_data
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int TW = TICK_BITS;

   logic [TW-1:0]     exp_ff  [SLOTS];
   logic [TW-1:0]     rel_ff  [SLOTS];
   logic [15:0]       cnt_ff  [SLOTS];
   logic              ntf_ff  [SLOTS];
   stq_pkg::mem_type  mem_ff  [SLOTS];
   logic [SW-1:0]     rank_ff [SLOTS];

   stq_pkg::state_type state_ff, state_in, after_rem;
   stq_pkg::mode_type  mode_ff, mode_in;
   stq_pkg::mem_type   phase_ff, phase_in, tgt_m_ff, tgt_m_in, mem_wval;
   logic [SW-1:0]      tgt_ff, tgt_in, idx_ff, idx_in, tgt_rank_ff, tgt_rank_in;
   logic [SW-1:0]      r_ff, r_in, rank_scan_val, rd_idx;
   logic [3:0]         slot_raw_ff, slot_raw_in;
   logic               slot_ok_ff, slot_ok_in;
   logic [TW-1:0]      now_ff, now_in, delay_ff, delay_in, rel_new_ff, rel_new_in;
   logic [TW-1:0]      tgt_exp_ff, tgt_exp_in;
   logic               ntf_new_ff, ntf_new_in;
   logic               pend_valid_ff, pend_valid_in, rsp_valid_ff, rsp_valid_in;
   stq_pkg::rsp_type   pend_ff, pend_in, rsp_ff, rsp_in;

   logic               mem_we, rank_scan_we, rank_tgt_we, exp_we, cfg_we, cnt_inc, out_load;
   logic [TW-1:0]      exp_rd, rel_rd, alu_a, alu_b, alu_sum;
   logic [15:0]        cnt_rd;
   logic               ntf_rd, alu_lt, idx_last, head_hit, out_free, fire_block, accept;
   stq_pkg::mem_type   mem_rd;
   logic [SW-1:0]      rank_rd;

   stq_alu #(.TW(TW)) u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .sum  (alu_sum),
      .lt   (alu_lt)
   );

   assign req_stall = state_ff != stq_pkg::ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (state_ff)
         stq_pkg::ST_REM_SCAN, stq_pkg::ST_ENQ_SCAN, stq_pkg::ST_HEAD_SCAN: rd_idx = idx_ff;
         default: rd_idx = tgt_ff;
      endcase
   end

   assign exp_rd   = exp_ff[rd_idx];
   assign rel_rd   = rel_ff[rd_idx];
   assign cnt_rd   = cnt_ff[rd_idx];
   assign ntf_rd   = ntf_ff[rd_idx];
   assign mem_rd   = mem_ff[rd_idx];
   assign rank_rd  = rank_ff[rd_idx];
   assign idx_last = idx_ff == SW'(SLOTS - 1);
   assign head_hit = (mem_rd == phase_ff) && (rank_rd == '0);
   assign fire_block = ntf_rd && pend_valid_ff && !out_free;

   always_comb begin
      case (state_ff)
         stq_pkg::ST_WRITE: begin
            alu_a = now_ff;
            alu_b = delay_ff;
         end
         stq_pkg::ST_FIRE: begin
            alu_a = now_ff;
            alu_b = rel_rd;
         end
         stq_pkg::ST_ENQ_SCAN: begin
            alu_a = tgt_exp_ff;
            alu_b = exp_rd;
         end
         stq_pkg::ST_HEAD_SCAN: begin
            if (phase_ff == stq_pkg::MEM_ROLL) begin
               alu_a = exp_rd;
               alu_b = now_ff;
            end else begin
               alu_a = now_ff;
               alu_b = exp_rd;
            end
         end
         default: begin
            alu_a = exp_rd;
            alu_b = now_ff;
         end
      endcase
   end

   always_comb begin
      case (mode_ff)
         stq_pkg::MODE_SETUP:  after_rem = stq_pkg::ST_WRITE;
         stq_pkg::MODE_TICK:   after_rem = (phase_ff == stq_pkg::MEM_ROLL) ?
                                           stq_pkg::ST_ENQ_START : stq_pkg::ST_FIRE;
         default:              after_rem = stq_pkg::ST_IDLE;
      endcase
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stq_pkg::ST_IDLE: begin
            if (req_valid) begin
               case (req_data.mode)
                  stq_pkg::MODE_TICK:  state_in = stq_pkg::ST_HEAD_SCAN;
                  stq_pkg::MODE_QUERY: state_in = stq_pkg::ST_QUERY;
                  default:             state_in = slot_ok_in ? stq_pkg::ST_REM_START :
                                                               stq_pkg::ST_IDLE;
               endcase
            end
         end
         stq_pkg::ST_REM_START: begin
            state_in = (mem_rd == stq_pkg::MEM_NONE) ? after_rem : stq_pkg::ST_REM_SCAN;
         end
         stq_pkg::ST_REM_SCAN: begin
            if (idx_last) state_in = after_rem;
         end
         stq_pkg::ST_WRITE: state_in = stq_pkg::ST_ENQ_START;
         stq_pkg::ST_ENQ_START: state_in = stq_pkg::ST_ENQ_SCAN;
         stq_pkg::ST_ENQ_SCAN: begin
            if (idx_last) begin
               state_in = (mode_ff == stq_pkg::MODE_SETUP) ? stq_pkg::ST_IDLE :
                                                             stq_pkg::ST_HEAD_SCAN;
            end
         end
         stq_pkg::ST_HEAD_SCAN: begin
            if (head_hit && !alu_lt) begin
               state_in = stq_pkg::ST_REM_START;
            end else if (head_hit || idx_last) begin
               state_in = (phase_ff == stq_pkg::MEM_ROLL) ? stq_pkg::ST_HEAD_SCAN :
                                                            stq_pkg::ST_FLUSH;
            end
         end
         stq_pkg::ST_FIRE: begin
            if (!fire_block) begin
               state_in = (rel_rd != '0) ? stq_pkg::ST_ENQ_START : stq_pkg::ST_HEAD_SCAN;
            end
         end
         stq_pkg::ST_FLUSH: begin
            if (!pend_valid_ff || out_free) state_in = stq_pkg::ST_IDLE;
         end
         stq_pkg::ST_QUERY: begin
            if (out_free) state_in = stq_pkg::ST_IDLE;
         end
         default: state_in = stq_pkg::ST_IDLE;
      endcase
   end

   // Datapath and store updates.
   always_comb begin
      mode_in       = mode_ff;
      phase_in      = phase_ff;
      tgt_in        = tgt_ff;
      tgt_m_in      = tgt_m_ff;
      tgt_rank_in   = tgt_rank_ff;
      tgt_exp_in    = tgt_exp_ff;
      r_in          = r_ff;
      slot_raw_in   = slot_raw_ff;
      slot_ok_in    = ({3'd0, req_data.slot} < 7'(SLOTS));
      now_in        = now_ff;
      delay_in      = delay_ff;
      rel_new_in    = rel_new_ff;
      ntf_new_in    = ntf_new_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      out_load      = 1'b0;
      idx_in        = '0;
      mem_we        = 1'b0;
      mem_wval      = stq_pkg::MEM_NONE;
      rank_scan_we  = 1'b0;
      rank_scan_val = rank_rd;
      rank_tgt_we   = 1'b0;
      exp_we        = 1'b0;
      cfg_we        = 1'b0;
      cnt_inc       = 1'b0;
      case (state_ff)
         stq_pkg::ST_IDLE: begin
            if (accept) begin
               mode_in     = req_data.mode;
               phase_in    = stq_pkg::MEM_ROLL;
               tgt_in      = SW'(req_data.slot);
               slot_raw_in = req_data.slot;
               now_in      = TW'(req_data.now_ticks);
               delay_in    = TW'(req_data.delay);
               rel_new_in  = TW'(req_data.reload);
               ntf_new_in  = req_data.notify;
            end
         end
         stq_pkg::ST_REM_START: begin
            tgt_m_in    = mem_rd;
            tgt_rank_in = rank_rd;
         end
         stq_pkg::ST_REM_SCAN: begin
            idx_in = idx_last ? '0 : SW'(idx_ff + 1'b1);
            if (mem_rd == tgt_m_ff && rank_rd > tgt_rank_ff) begin
               rank_scan_we  = 1'b1;
               rank_scan_val = SW'(rank_rd - 1'b1);
            end
            if (idx_last) begin
               mem_we   = 1'b1;
               mem_wval = stq_pkg::MEM_NONE;
            end
         end
         stq_pkg::ST_WRITE: begin
            exp_we = 1'b1;
            cfg_we = 1'b1;
         end
         stq_pkg::ST_ENQ_START: begin
            tgt_exp_in = exp_rd;
            tgt_m_in   = alu_lt ? stq_pkg::MEM_ROLL : stq_pkg::MEM_MAIN;
            r_in       = '0;
         end
         stq_pkg::ST_ENQ_SCAN: begin
            idx_in = idx_last ? '0 : SW'(idx_ff + 1'b1);
            if (idx_ff != tgt_ff && mem_rd == tgt_m_ff) begin
               if (!alu_lt) begin
                  r_in = SW'(r_ff + 1'b1);
               end else begin
                  rank_scan_we  = 1'b1;
                  rank_scan_val = SW'(rank_rd + 1'b1);
               end
            end
            if (idx_last) begin
               rank_tgt_we = 1'b1;
               mem_we      = 1'b1;
               mem_wval    = tgt_m_ff;
            end
         end
         stq_pkg::ST_HEAD_SCAN: begin
            idx_in = (idx_last || head_hit) ? '0 : SW'(idx_ff + 1'b1);
            if (head_hit && !alu_lt) begin
               tgt_in = idx_ff;
            end else if (head_hit || idx_last) begin
               phase_in = stq_pkg::MEM_MAIN;
            end
         end
         stq_pkg::ST_FIRE: begin
            if (!fire_block) begin
               cnt_inc = 1'b1;
               if (ntf_rd) begin
                  if (pend_valid_ff) begin
                     out_load = 1'b1;
                     rsp_in   = pend_ff;
                  end
                  pend_valid_in      = 1'b1;
                  pend_in.kind       = stq_pkg::KIND_EXPIRY;
                  pend_in.fired_slot = 4'(tgt_ff);
                  pend_in.fire_time  = 32'(now_ff);
                  pend_in.count      = cnt_rd + 16'd1;
                  pend_in.queued     = 1'b0;
                  pend_in.last       = 1'b0;
               end
               exp_we = rel_rd != '0;
            end
         end
         stq_pkg::ST_FLUSH: begin
            if (pend_valid_ff && out_free) begin
               out_load      = 1'b1;
               rsp_in        = pend_ff;
               rsp_in.last   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         stq_pkg::ST_QUERY: begin
            if (out_free) begin
               out_load          = 1'b1;
               rsp_in.kind       = stq_pkg::KIND_QUERY;
               rsp_in.fired_slot = slot_raw_ff;
               rsp_in.fire_time  = '0;
               rsp_in.count      = '0;
               rsp_in.queued     = slot_ok_ff && (mem_rd != stq_pkg::MEM_NONE);
               rsp_in.last       = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= stq_pkg::ST_IDLE;
         mode_ff       <= stq_pkg::MODE_TICK;
         phase_ff      <= stq_pkg::MEM_ROLL;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         phase_ff      <= phase_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff      <= tgt_in;
      tgt_m_ff    <= tgt_m_in;
      tgt_rank_ff <= tgt_rank_in;
      tgt_exp_ff  <= tgt_exp_in;
      r_ff        <= r_in;
      slot_raw_ff <= slot_raw_in;
      if (accept) slot_ok_ff <= slot_ok_in;
      now_ff      <= now_in;
      delay_ff    <= delay_in;
      rel_new_ff  <= rel_new_in;
      ntf_new_ff  <= ntf_new_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) mem_ff[i] <= stq_pkg::MEM_NONE;
      end else if (mem_we) begin
         mem_ff[tgt_ff] <= mem_wval;
      end
   end

   always_ff @(posedge clock) begin
      if (rank_scan_we) rank_ff[idx_ff] <= rank_scan_val;
      if (rank_tgt_we) rank_ff[tgt_ff] <= r_in;
      if (exp_we) exp_ff[tgt_ff] <= alu_sum;
      if (cfg_we) begin
         rel_ff[tgt_ff] <= rel_new_ff;
         ntf_ff[tgt_ff] <= ntf_new_ff;
         cnt_ff[tgt_ff] <= '0;
      end else if (cnt_inc) begin
         cnt_ff[tgt_ff] <= cnt_rd + 16'd1;
      end
   end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int SLOTS = 16;
   localparam int WATCHDOG_LIMIT = 20000;

   class timer_scoreboard;
      logic [31:0]      expiry[SLOTS];
      logic [31:0]      period[SLOTS];
      logic [15:0]      fires[SLOTS];
      logic             notify_on[SLOTS];
      stq_pkg::mem_type member[SLOTS];
      int               rank[SLOTS];
      stq_pkg::rsp_type pending[$];
      int               mismatches;

      function new();
         mismatches = 0;
         foreach (member[i]) begin
            member[i] = stq_pkg::MEM_NONE;
            rank[i] = 0;
         end
      endfunction

      function void unlink(int s);
         if (member[s] == stq_pkg::MEM_NONE) return;
         for (int i = 0; i < SLOTS; i++)
            if (member[i] == member[s] && rank[i] > rank[s]) rank[i]--;
         member[s] = stq_pkg::MEM_NONE;
      endfunction

      function void link(int s, logic [31:0] now);
         stq_pkg::mem_type m;
         int               r;
         m = (expiry[s] >= now) ? stq_pkg::MEM_MAIN : stq_pkg::MEM_ROLL;
         r = 0;
         for (int i = 0; i < SLOTS; i++) begin
            if (i == s || member[i] != m) continue;
            if (expiry[i] <= expiry[s]) r++;
            else rank[i]++;
         end
         rank[s] = r;
         member[s] = m;
      endfunction

      function int head_of(stq_pkg::mem_type m);
         for (int i = 0; i < SLOTS; i++)
            if (member[i] == m && rank[i] == 0) return i;
         return -1;
      endfunction

      function void note_request(stq_pkg::req_type t);
         stq_pkg::rsp_type r;
         int               h;
         int               first;
         int               s;
         s = t.slot;
         first = pending.size();
         case (t.mode)
            stq_pkg::MODE_TICK: begin
               forever begin
                  h = head_of(stq_pkg::MEM_ROLL);
                  if (h < 0 || expiry[h] < t.now_ticks) break;
                  unlink(h);
                  link(h, t.now_ticks);
               end
               forever begin
                  h = head_of(stq_pkg::MEM_MAIN);
                  if (h < 0 || expiry[h] > t.now_ticks) break;
                  unlink(h);
                  fires[h]++;
                  if (notify_on[h]) begin
                     r = '0;
                     r.kind = stq_pkg::KIND_EXPIRY;
                     r.fired_slot = 4'(h);
                     r.fire_time = t.now_ticks;
                     r.count = fires[h];
                     pending.push_back(r);
                  end
                  if (period[h] != 0) begin
                     expiry[h] = t.now_ticks + period[h];
                     link(h, t.now_ticks);
                  end
               end
               if (pending.size() > first) pending[pending.size() - 1].last = 1'b1;
            end
            stq_pkg::MODE_SETUP: begin
               unlink(s);
               expiry[s] = t.now_ticks + t.delay;
               period[s] = t.reload;
               fires[s] = '0;
               notify_on[s] = t.notify;
               link(s, t.now_ticks);
            end
            stq_pkg::MODE_DELETE: unlink(s);
            default: begin
               r = '0;
               r.kind = stq_pkg::KIND_QUERY;
               r.fired_slot = 4'(s);
               r.queued = (member[s] != stq_pkg::MEM_NONE);
               r.last = 1'b1;
               pending.push_back(r);
            end
         endcase
      endfunction

      function void check_result(stq_pkg::rsp_type got);
         stq_pkg::rsp_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   stq_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   stq_pkg::rsp_type rsp_data;

   timer_scoreboard board;
   int idle_cycles;
   bit sending_done;
   bit timed_out;
   logic [31:0] clock_ticks;

   sorted_timer_queue dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic send(stq_pkg::req_type t);
      int gap;
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_stall);
      board.note_request(t);
   endtask

   function automatic stq_pkg::req_type make(stq_pkg::mode_type m, int s, logic [31:0] now,
                                             logic [31:0] d, logic [31:0] rl, logic n);
      stq_pkg::req_type t;
      t.mode = m;
      t.slot = 4'(s);
      t.now_ticks = now;
      t.delay = d;
      t.reload = rl;
      t.notify = n;
      return t;
   endfunction

   task automatic tick_at(logic [31:0] now);
      send(make(stq_pkg::MODE_TICK, $urandom_range(0, 15), now, $urandom, $urandom,
                1'($urandom_range(0, 1))));
   endtask

   task automatic arm(int s, logic [31:0] d, logic [31:0] rl, logic n);
      send(make(stq_pkg::MODE_SETUP, s, clock_ticks, d, rl, n));
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   initial begin
      int k;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      sending_done = 1'b0;
      clock_ticks = 32'd100;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(make(stq_pkg::MODE_QUERY, 0, 0, 0, 0, 0));
      tick_at(32'd50);
      arm(0, 32'd5, 32'd0, 1'b1);
      arm(1, 32'd5, 32'd3, 1'b1);
      arm(2, 32'd0, 32'd0, 1'b1);
      arm(3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      arm(4, 32'd7, 32'd0, 1'b0);
      send(make(stq_pkg::MODE_QUERY, 3, 0, 0, 0, 0));
      send(make(stq_pkg::MODE_DELETE, 9, 0, 0, 0, 0));
      send(make(stq_pkg::MODE_DELETE, 4, 0, 0, 0, 0));
      send(make(stq_pkg::MODE_QUERY, 4, 0, 0, 0, 0));
      arm(0, 32'd6, 32'd0, 1'b1);
      tick_at(32'd110);
      tick_at(32'd200);
      tick_at(32'hFFFF_FFF0);
      tick_at(32'd10);
      tick_at(32'd99);
      tick_at(32'hFFFF_FFFF);
      send(make(stq_pkg::MODE_QUERY, 15, 0, 0, 0, 0));
      drain();

      clock_ticks = 32'd0;
      for (int i = 0; i < 200; i++) begin
         k = $urandom_range(0, 99);
         if (k < 40) begin
            arm($urandom_range(0, 15),
                ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40),
                ($urandom_range(0, 2) == 0) ? 32'd0 :
                ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 30),
                $urandom_range(0, 3) != 0);
         end else if (k < 75) begin
            if ($urandom_range(0, 19) == 0) clock_ticks = $urandom;
            else clock_ticks = clock_ticks + $urandom_range(0, 20);
            tick_at(clock_ticks);
         end else if (k < 85) begin
            send(make(stq_pkg::MODE_DELETE, $urandom_range(0, 15), $urandom, $urandom,
                      $urandom, 1'($urandom_range(0, 1))));
         end else begin
            send(make(stq_pkg::MODE_QUERY, $urandom_range(0, 15), $urandom, $urandom,
                      $urandom, 1'($urandom_range(0, 1))));
         end
         if (i == 100) drain();
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   initial begin
      idle_cycles = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            board.check_result(rsp_data);
            idle_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
         end
         if (idle_cycles > 0) begin
            idle_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      timed_out = 1'b0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
         if (quiet >= WATCHDOG_LIMIT) begin
            timed_out = 1'b1;
            break;
         end
         if (sending_done && board.pending.size() == 0) break;
      end
      if (timed_out) begin
         $display("Simulation FAILED");
      end else begin
         repeat (200) @(posedge clock);
         if (board.mismatches == 0 && board.pending.size() == 0) $display("Simulation PASSED");
         else $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
